### rtl/cdtp_pkg.sv
// ----------------------------------------------------------------------------
// CD-TEXT pack parser package
// Pack layout constants, pack type codes and the result record.
// ----------------------------------------------------------------------------
package cdtp_pkg;

  localparam int unsigned PACK_BYTES  = 18;
  localparam int unsigned TEXT_BYTES  = 12;
  localparam int unsigned TEXT_FIRST  = 4;
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned MAX_PACKS   = 255;

  localparam logic [7:0] TYPE_TITLE     = 8'h80;
  localparam logic [7:0] TYPE_PERFORMER = 8'h81;
  localparam logic [7:0] TYPE_MESSAGE   = 8'h85;

  localparam logic [1:0] KIND_TITLE     = 2'd0;
  localparam logic [1:0] KIND_PERFORMER = 2'd1;
  localparam logic [1:0] KIND_MESSAGE   = 2'd2;

  typedef struct packed {
    logic [7:0] text_char;
    logic [7:0] track_number;
    logic [1:0] text_kind;
    logic       string_end;
  } result_t;

  typedef struct packed {
    logic    valid;
    logic [1:0] code;
  } kind_t;

  function automatic kind_t kind_decode(input logic [7:0] pack_type);
    kind_t k;
    k.valid = 1'b1;
    case (pack_type)
      TYPE_TITLE:     k.code = KIND_TITLE;
      TYPE_PERFORMER: k.code = KIND_PERFORMER;
      TYPE_MESSAGE:   k.code = KIND_MESSAGE;
      default: begin
        k.valid = 1'b0;
        k.code  = KIND_TITLE;
      end
    endcase
    return k;
  endfunction

endpackage

### rtl/cdtp_if.sv
// ----------------------------------------------------------------------------
// CD-TEXT pack parser stream interfaces
// Valid/ready channels for response bytes and text results.
// ----------------------------------------------------------------------------
interface cdtp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, data_byte, start_req, input ready);
  modport sink   (input valid, data_byte, start_req, output ready);
endinterface

interface cdtp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic [7:0] track_number;
  logic [1:0] text_kind;
  logic       string_end;

  modport source (output valid, text_char, track_number, text_kind, string_end,
                  input ready);
  modport sink   (input valid, text_char, track_number, text_kind, string_end,
                  output ready);
endinterface

### rtl/cdtp_result_reg.sv
// ----------------------------------------------------------------------------
// CD-TEXT result register
// Holds one result until the downstream transfer; reports room for a load.
// ----------------------------------------------------------------------------
module cdtp_result_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  cdtp_pkg::result_t    result,
  output logic                 room,
  cdtp_out_if.source           out_stream
);

  logic              valid;
  cdtp_pkg::result_t held;

  assign room = !valid || out_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_stream.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign out_stream.valid        = valid;
  assign out_stream.text_char    = held.text_char;
  assign out_stream.track_number = held.track_number;
  assign out_stream.text_kind    = held.text_kind;
  assign out_stream.string_end   = held.string_end;

endmodule

### rtl/cd_text_pack_parser.sv
// ----------------------------------------------------------------------------
// CD-TEXT pack parser
// Skips the response header, checks 18-byte packs and streams out text.
// ----------------------------------------------------------------------------
// One response byte is taken per clock whenever the result register is empty
// or being drained in the same cycle; each byte is decoded in that cycle and
// its character (if any) appears on the output in the next cycle. Throughput is
// one byte per cycle, limited only by backpressure on the single-entry result
// register. Title, performer and message packs of the selected block whose
// sequence numbers run in order produce one result per text byte; a zero byte
// gives a string end and bumps the track. An out-of-order pack or the 255th
// pack stops parsing until a byte arrives with start_req set.
module cd_text_pack_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  cdtp_in_if.sink     in_stream,
  cdtp_out_if.source  out_stream
);

  logic [2:0] block_select;
  logic [2:0] header_left, header_left_next;
  logic [4:0] byte_position, byte_position_next;
  logic [7:0] expected_sequence, expected_sequence_next;
  logic       halted, halted_next;
  logic       pack_accepted, pack_accepted_next;
  cdtp_pkg::kind_t pack_kind, pack_kind_next;
  logic [7:0] track_counter, track_counter_next;

  logic       room;
  logic       xfer;
  logic       emit;
  cdtp_pkg::result_t result;

  logic [2:0] hl;
  logic [4:0] pos;
  logic [7:0] seq;
  logic [7:0] seq_inc;
  logic       halt_in;
  logic       acc_in;
  logic [7:0] b;

  assign in_stream.ready = room;
  assign xfer = in_stream.valid && room;
  assign b    = in_stream.data_byte;

  always_comb begin
    hl      = in_stream.start_req ? 3'(cdtp_pkg::HEADER_BYTES) : header_left;
    pos     = in_stream.start_req ? 5'd0 : byte_position;
    seq     = in_stream.start_req ? 8'd0 : expected_sequence;
    halt_in = in_stream.start_req ? 1'b0 : halted;
    acc_in  = in_stream.start_req ? 1'b0 : pack_accepted;
    seq_inc = seq + 8'd1;

    header_left_next       = hl;
    byte_position_next     = pos;
    expected_sequence_next = seq;
    halted_next            = halt_in;
    pack_accepted_next     = acc_in;
    pack_kind_next         = pack_kind;
    track_counter_next     = track_counter;
    emit                   = 1'b0;
    result.text_char       = b;
    result.track_number    = track_counter;
    result.text_kind       = pack_kind.code;
    result.string_end      = (b == 8'd0);

    if (halt_in) begin
      // ignore
    end else if (hl != 3'd0) begin
      header_left_next = hl - 3'd1;
    end else if (pos == 5'd2 && b != seq) begin
      halted_next = 1'b1;
    end else begin
      if (pos == 5'd0) begin
        pack_kind_next     = cdtp_pkg::kind_decode(b);
        pack_accepted_next = 1'b0;
      end else if (pos == 5'd1) begin
        track_counter_next = b;
      end else if (pos == 5'd3) begin
        pack_accepted_next = pack_kind.valid && (b[6:4] == block_select);
      end else if (pos >= 5'(cdtp_pkg::TEXT_FIRST) &&
                   pos < 5'(cdtp_pkg::TEXT_FIRST + cdtp_pkg::TEXT_BYTES)) begin
        if (acc_in && pack_kind.valid) begin
          emit = 1'b1;
          if (b == 8'd0) begin
            track_counter_next = track_counter + 8'd1;
          end
        end
      end

      if (pos == 5'(cdtp_pkg::PACK_BYTES - 1)) begin
        byte_position_next     = 5'd0;
        pack_accepted_next     = 1'b0;
        expected_sequence_next = seq_inc;
        if (seq_inc >= 8'(cdtp_pkg::MAX_PACKS) || seq_inc == 8'd0) begin
          halted_next = 1'b1;
        end
      end else begin
        byte_position_next = pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_select      <= 3'd0;
      header_left       <= 3'(cdtp_pkg::HEADER_BYTES);
      byte_position     <= 5'd0;
      expected_sequence <= 8'd0;
      halted            <= 1'b0;
      pack_accepted     <= 1'b0;
      pack_kind         <= '0;
      track_counter     <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        block_select <= cfg_wr_data;
      end
      if (xfer) begin
        header_left       <= header_left_next;
        byte_position     <= byte_position_next;
        expected_sequence <= expected_sequence_next;
        halted            <= halted_next;
        pack_accepted     <= pack_accepted_next;
        pack_kind         <= pack_kind_next;
        track_counter     <= track_counter_next;
      end
    end
  end

  cdtp_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (xfer && emit),
    .result     (result),
    .room       (room),
    .out_stream (out_stream)
  );

  a_end_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid && out_stream.string_end |-> out_stream.text_char == 8'd0)
    else $error("string end with nonzero character");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_stream.valid |-> out_stream.text_kind != 2'd3)
    else $error("illegal text kind");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted && !(xfer && in_stream.start_req) |=> halted)
    else $error("halt released without start");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position < 5'(cdtp_pkg::PACK_BYTES))
    else $error("byte position out of pack");

  a_accept_needs_kind: assert property (@(posedge clk) disable iff (rst)
    pack_accepted |-> pack_kind.valid)
    else $error("pack accepted with unknown type");

endmodule

### bench/tb_cd_text_pack_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CD-TEXT pack parser testbench
// Streams CD-TEXT responses (header, packs, broken and noisy input) into the
// parser under random source and sink stalls. A bit-accurate predictor
// tracks header, pack position, sequence, halt and track state and checks
// each text transfer in order. The language block setting is swept between
// phases.
// ----------------------------------------------------------------------------
module tb_cd_text_pack_parser;

  localparam logic [7:0] TYPE_SONGWRITER = 8'h82;
  localparam int unsigned PHASES = 9;
  localparam int unsigned PHASE_BYTES = 165;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } resp_byte_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [2:0] cfg_wr_data;

  cdtp_in_if  in_s ();
  cdtp_out_if out_s ();

  cd_text_pack_parser dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_stream   (in_s),
    .out_stream  (out_s)
  );

  // parser state as predicted
  logic [2:0] blk_sel   = 3'd0;
  logic [2:0] hdr_left  = 3'd4;
  logic [4:0] byte_pos  = 5'd0;
  logic [7:0] seq_want  = 8'd0;
  logic       halt      = 1'b0;
  logic [7:0] pack_type = 8'd0;
  logic       pack_ok   = 1'b0;
  logic [7:0] track     = 8'd0;

  resp_byte_t         resp_q[$];
  cdtp_pkg::result_t  text_q[$];

  bit idle_on = 1'b1;
  int src_gap, src_calm, snk_gap, snk_calm;
  int queued, bytes_in, chars_seen, ends_seen, errors;

  function automatic bit kind_of(input logic [7:0] t, output logic [1:0] k);
    k = cdtp_pkg::KIND_TITLE;
    if (t == cdtp_pkg::TYPE_TITLE) return 1'b1;
    if (t == cdtp_pkg::TYPE_PERFORMER) begin
      k = cdtp_pkg::KIND_PERFORMER;
      return 1'b1;
    end
    if (t == cdtp_pkg::TYPE_MESSAGE) begin
      k = cdtp_pkg::KIND_MESSAGE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit predict_text(input logic [7:0] b, input logic start,
                                      output cdtp_pkg::result_t r);
    logic [4:0] pos;
    logic [1:0] k;
    bit         hit;
    r = '0;
    hit = 1'b0;
    if (start) begin
      hdr_left = 3'd4;
      byte_pos = 5'd0;
      seq_want = 8'd0;
      halt     = 1'b0;
      pack_ok  = 1'b0;
    end
    if (halt) return 1'b0;
    if (hdr_left != 3'd0) begin
      hdr_left = hdr_left - 3'd1;
      return 1'b0;
    end
    pos = byte_pos;
    if (pos == 5'd0) begin
      pack_type = b;
      pack_ok   = 1'b0;
    end else if (pos == 5'd1) begin
      track = b;
    end else if (pos == 5'd2) begin
      if (b != seq_want) begin
        halt = 1'b1;
        return 1'b0;
      end
    end else if (pos == 5'd3) begin
      pack_ok = kind_of(pack_type, k) && (b[6:4] == blk_sel);
    end else if (pos >= cdtp_pkg::TEXT_FIRST &&
                 pos < cdtp_pkg::TEXT_FIRST + cdtp_pkg::TEXT_BYTES) begin
      if (pack_ok && kind_of(pack_type, k)) begin
        r.text_char    = b;
        r.track_number = track;
        r.text_kind    = k;
        r.string_end   = (b == 8'd0);
        hit = 1'b1;
        if (b == 8'd0) track = track + 8'd1;
      end
    end
    if (pos + 1 >= cdtp_pkg::PACK_BYTES) begin
      byte_pos = 5'd0;
      pack_ok  = 1'b0;
      seq_want = seq_want + 8'd1;
      if (seq_want >= cdtp_pkg::MAX_PACKS || seq_want == 8'd0) halt = 1'b1;
    end else begin
      byte_pos = pos + 5'd1;
    end
    return hit;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic s);
    resp_q.push_back('{data: b, start: s});
    queued++;
  endtask

  task automatic add_pack(input logic [7:0] t, input logic [7:0] trk,
                          input logic [7:0] sq, input logic [7:0] blk);
    push_byte(t, 1'b0);
    push_byte(trk, 1'b0);
    push_byte(sq, 1'b0);
    push_byte(blk, 1'b0);
    repeat (cdtp_pkg::TEXT_BYTES)
      push_byte(($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 255)), 1'b0);
    repeat (2) push_byte(8'($urandom), 1'b0);
  endtask

  // one response; fault_pct > 0 allows bad sequence numbers and truncation
  task automatic add_response(input int npacks, input int fault_pct);
    logic [7:0] t, trk, sq, blk;
    push_byte(8'($urandom), 1'b1);
    repeat (3) push_byte(8'($urandom), 1'b0);
    for (int n = 0; n < npacks; n++) begin
      if (fault_pct > 0 && $urandom_range(0, 99) < fault_pct / 2) begin
        repeat ($urandom_range(1, cdtp_pkg::PACK_BYTES - 1))
          push_byte(8'($urandom), 1'b0);
        return;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: t = cdtp_pkg::TYPE_TITLE;
        3, 4:    t = cdtp_pkg::TYPE_PERFORMER;
        5, 6:    t = cdtp_pkg::TYPE_MESSAGE;
        7:       t = TYPE_SONGWRITER + 8'($urandom_range(0, 2));
        default: t = 8'($urandom);
      endcase
      trk = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      sq  = 8'(n);
      if (fault_pct > 0 && $urandom_range(0, 99) < fault_pct)
        sq = 8'(n + $urandom_range(1, 255));
      blk = 8'($urandom);
      if ($urandom_range(0, 99) < 85) blk[6:4] = blk_sel;
      add_pack(t, trk, sq, blk);
    end
  endtask

  task automatic wait_drain();
    while (resp_q.size() != 0 || in_s.valid || out_s.valid || text_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_block(input logic [2:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    blk_sel = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // source side
  always @(posedge clk) begin
    if (rst) begin
      in_s.valid     <= 1'b0;
      in_s.data_byte <= 8'd0;
      in_s.start_req <= 1'b0;
      src_gap  = 0;
      src_calm = 0;
    end else if (!in_s.valid || in_s.ready) begin : src_step
      resp_byte_t nxt;
      if (src_calm > 0) src_calm--;
      else if ($urandom_range(0, 199) == 0) src_calm = $urandom_range(30, 150);
      if (src_gap > 0) begin
        src_gap--;
        in_s.valid <= 1'b0;
      end else if (resp_q.size() != 0) begin
        nxt = resp_q.pop_front();
        in_s.valid     <= 1'b1;
        in_s.data_byte <= nxt.data;
        in_s.start_req <= nxt.start;
        if (idle_on && src_calm == 0 && $urandom_range(0, 7) == 0)
          src_gap = $urandom_range(1, 15);
      end else begin
        in_s.valid <= 1'b0;
      end
    end
  end

  // sink side
  always @(posedge clk) begin
    if (rst) begin
      out_s.ready <= 1'b0;
      snk_gap  = 0;
      snk_calm = 0;
    end else begin
      if (snk_calm > 0) snk_calm--;
      else if ($urandom_range(0, 199) == 0) snk_calm = $urandom_range(30, 150);
      if (snk_gap > 0) begin
        snk_gap--;
        out_s.ready <= 1'b0;
      end else begin
        out_s.ready <= 1'b1;
        if (idle_on && snk_calm == 0 && $urandom_range(0, 9) == 0)
          snk_gap = $urandom_range(1, 15);
      end
    end
  end

  // output checked before input is predicted: a result never follows its byte
  // in the same cycle
  always @(posedge clk) begin
    if (!rst) begin : mon_step
      cdtp_pkg::result_t got, want;
      bit                bad;
      if (out_s.valid && out_s.ready) begin
        got.text_char    = out_s.text_char;
        got.track_number = out_s.track_number;
        got.text_kind    = out_s.text_kind;
        got.string_end   = out_s.string_end;
        if (got.string_end === 1'b1) ends_seen++;
        else chars_seen++;
        if (text_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected text transfer: char %02h trk %0d kind %0d end %0b",
                     got.text_char, got.track_number, got.text_kind, got.string_end);
        end else begin
          want = text_q.pop_front();
          bad = (got.text_char !== want.text_char) ||
                (got.track_number !== want.track_number) ||
                (got.text_kind !== want.text_kind) ||
                (got.string_end !== want.string_end);
          if (bad) begin
            errors++;
            if (errors <= 10)
              $display({"text mismatch: want char %02h trk %0d kind %0d end %0b, ",
                        "got char %02h trk %0d kind %0d end %0b"},
                       want.text_char, want.track_number, want.text_kind,
                       want.string_end, got.text_char, got.track_number,
                       got.text_kind, got.string_end);
          end
        end
      end
      if (in_s.valid && in_s.ready) begin
        bytes_in++;
        if (predict_text(in_s.data_byte, in_s.start_req, want)) text_q.push_back(want);
      end
    end
  end

  initial begin : stim
    logic [2:0] plan [PHASES] = '{3'd7, 3'd0, 3'd5, 3'd2, 3'd7, 3'd1, 3'd6, 3'd3, 3'd4};
    int         mark;
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 3'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every kind, wrong block, other type, sequence break
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(cdtp_pkg::TYPE_TITLE, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h8F, 1'b0);
    foreach (plan[i]) push_byte((i % 2) ? 8'h00 : 8'hFF - 8'(i), 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    add_pack(cdtp_pkg::TYPE_PERFORMER, 8'h00, 8'd1, 8'h0F);
    add_pack(cdtp_pkg::TYPE_MESSAGE, 8'h05, 8'd2, 8'hF0);
    add_pack(cdtp_pkg::TYPE_MESSAGE, 8'h07, 8'd3, 8'h70);
    add_pack(TYPE_SONGWRITER, 8'h01, 8'd4, 8'h00);
    push_byte(cdtp_pkg::TYPE_TITLE, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'd9, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h3C, 1'b1);
    wait_drain();

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != PHASES - 1);
      set_block(plan[p]);
      mark = queued;
      while (queued - mark < PHASE_BYTES) begin
        if ($urandom_range(0, 9) < 8)
          add_response($urandom_range(1, 4), 8);
        else
          repeat ($urandom_range(1, 12))
            push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
      wait_drain();
    end
    repeat (8) @(posedge clk);

    if (text_q.size() != 0) begin
      errors++;
      $display("%0d expected text transfers never arrived", text_q.size());
    end
    $display("covered %0d response bytes over %0d block settings", bytes_in, PHASES + 1);
    $display("checked %0d characters and %0d string ends", chars_seen, ends_seen);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
rtl/cdtp_pkg.sv
rtl/cdtp_if.sv
rtl/cdtp_result_reg.sv
rtl/cd_text_pack_parser.sv
bench/tb_cd_text_pack_parser.sv
